// ===== rtl/core/c3f_pkg.sv =====
// Package for the 3x3 convolution core: sizes, register indexes, reset values
// and the shared types. No dependencies; every other file of the core imports it.
package c3f_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W    = 16;
	localparam int COEF_W   = 16;
	localparam int PROD_W   = 32;
	localparam int COLSUM_W = 34;
	localparam int SUM_W    = 36;
	localparam int KROW_W   = 48;
	localparam int DIMCFG_W = 11;
	localparam int CFGIDX_W = 3;

	// Smallest legal frame dimension, and the first row and column that close a window.
	localparam int DIM_MIN  = 3;
	localparam int EDGE_MIN = 2;

	typedef logic [CFGIDX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_KROW_TOP = 3'd0;
	localparam cfg_index_t REG_KROW_MID = 3'd1;
	localparam cfg_index_t REG_KROW_BOT = 3'd2;
	localparam cfg_index_t REG_WIDTH    = 3'd3;
	localparam cfg_index_t REG_HEIGHT   = 3'd4;

	localparam logic [KROW_W-1:0]   KROW_RESET = 48'h0001_0001_0001;
	localparam logic [DIMCFG_W-1:0] DIM_RESET  = 11'd1024;

	typedef logic signed [PIX_W-1:0]    pix_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [COLSUM_W-1:0] colsum_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	// One window column or one kernel column: index 0 is the top row.
	typedef pix_t [2:0] pix_col_t;

	// One line store entry: the previous row and the row before it.
	typedef struct packed {
		pix_t row1;
		pix_t row2;
	} line_pair_t;

	// Position flags that travel with a pixel down the pipeline.
	typedef struct packed {
		logic emit;
		logic last;
	} pos_tag_t;

	// Per-cell enables driven by the top level's pipeline control.
	typedef struct packed {
		logic shift;
		logic sum_en;
	} cell_ctl_t;

endpackage

// ===== rtl/core/c3f_pixel_if.sv =====
// Input channel of the convolution core: valid/ready handshake and one signed pixel.
// Depends on c3f_pkg.
interface c3f_pixel_if;
	import c3f_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

// ===== rtl/core/c3f_result_if.sv =====
// Output channel of the convolution core: valid/ready handshake, the sum and the
// frame end flag. Depends on c3f_pkg.
interface c3f_result_if;
	import c3f_pkg::*;

	logic valid;
	logic ready;
	sum_t filtered;
	logic frame_end;

	modport source (output valid, output filtered, output frame_end, input ready);
	modport sink (input valid, input filtered, input frame_end, output ready);
endinterface

// ===== rtl/core/c3f_line_store.sv =====
// Line store of the convolution core: one entry per column holding the two previous
// image rows. One registered read port, one write port. Depends on c3f_pkg.
module c3f_line_store #(
	parameter int DEPTH = c3f_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output c3f_pkg::line_pair_t      rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  c3f_pkg::line_pair_t      wr_data
);
	import c3f_pkg::*;

	line_pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ===== rtl/core/c3f_cell.sv =====
// One window column cell of the convolution core: holds three pixels, hands them to
// its left neighbour and forms the column's dot product in two stages. Depends on c3f_pkg.
module c3f_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  c3f_pkg::cell_ctl_t  ctl,
	input  c3f_pkg::pix_col_t   col_in,
	input  c3f_pkg::pix_col_t   coef,
	output c3f_pkg::pix_col_t   col_out,
	output c3f_pkg::colsum_t    colsum
);
	import c3f_pkg::*;

	pix_col_t win_q;
	prod_t    prod_s2 [3];
	colsum_t  sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= col_in;
		end
	end

	// The products are taken from the column as it enters, so they belong to the
	// window that this shift creates.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= $signed(col_in[i]) * $signed(coef[i]);
			end
		end
		if (ctl.sum_en) begin
			sum_s3 <= colsum_t'(prod_s2[0]) + colsum_t'(prod_s2[1]) + colsum_t'(prod_s2[2]);
		end
	end

	assign col_out = win_q;
	assign colsum  = sum_s3;

endmodule

// ===== rtl/core/conv3x3_image_filter_core.sv =====
// Top level of the streaming 3x3 convolution core: configuration registers, position
// counters, pipeline control, line store and the row of three window cells.
// Depends on c3f_pkg, c3f_pixel_if, c3f_result_if, c3f_line_store and c3f_cell.
// Results pass stage one, products, column sums and the output register. Throughput: one
// pixel per clock unless the output stalls; each stage is a fixed register, the line store
// has a separate read and write port, and the nine products run in parallel in the cells.
// Reset clears the counters, the window and the pipeline, and restores the kernel to all
// ones and both dimensions to 1024; the line store is not cleared and needs no sweep.
module conv3x3_image_filter_core #(
	parameter int MAX_WIDTH  = c3f_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = c3f_pkg::MAX_HEIGHT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  c3f_pkg::cfg_index_t      cfg_index,
	input  logic [c3f_pkg::KROW_W-1:0] cfg_data,
	c3f_pixel_if.sink                pixels,
	c3f_result_if.source             results
);
	import c3f_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	// Compare width: wide enough for the configured value and for a counter plus one.
	localparam int DIM_A = (COL_W + 1 > DIMCFG_W) ? COL_W + 1 : DIMCFG_W;
	localparam int DIM_W = (ROW_W + 1 > DIM_A) ? ROW_W + 1 : DIM_A;

	// ------------------------------------------------------------------
	// Configuration registers. The user must write only while the core is idle, unchecked.
	// ------------------------------------------------------------------
	logic [KROW_W-1:0]   krow_q [3];
	logic [DIMCFG_W-1:0] width_q;
	logic [DIMCFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			krow_q[0] <= KROW_RESET;
			krow_q[1] <= KROW_RESET;
			krow_q[2] <= KROW_RESET;
			width_q   <= DIM_RESET;
			height_q  <= DIM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KROW_TOP: krow_q[0] <= cfg_data;
				REG_KROW_MID: krow_q[1] <= cfg_data;
				REG_KROW_BOT: krow_q[2] <= cfg_data;
				REG_WIDTH:    width_q   <= cfg_data[DIMCFG_W-1:0];
				REG_HEIGHT:   height_q  <= cfg_data[DIMCFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Out-of-range dimensions saturate into the legal range.
	logic [DIM_W-1:0] w_cfg, h_cfg, w_eff, h_eff;

	always_comb begin
		w_cfg = DIM_W'(width_q);
		h_cfg = DIM_W'(height_q);
		if (w_cfg < DIM_W'(DIM_MIN)) begin
			w_eff = DIM_W'(DIM_MIN);
		end else if (w_cfg > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = w_cfg;
		end
		if (h_cfg < DIM_W'(DIM_MIN)) begin
			h_eff = DIM_W'(DIM_MIN);
		end else if (h_cfg > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = h_cfg;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control. Each stage moves on when the one below it is free;
	// a pixel at the border leaves stage three without using the output
	// register, so border pixels never hold up the stream.
	// ------------------------------------------------------------------
	logic     v_s1, v_s2, v_s3, out_v_q;
	pos_tag_t tag_s1, tag_s2, tag_s3;
	logic     rdy_out, free3, free2, free1;
	logic     accept;

	assign rdy_out = !out_v_q || results.ready;
	assign free3   = !v_s3 || !tag_s3.emit || rdy_out;
	assign free2   = !v_s2 || free3;
	assign free1   = !v_s1 || free2;
	assign accept  = pixels.valid && free1;

	assign pixels.ready = free1;

	// ------------------------------------------------------------------
	// Position counters, advanced on every pixel transfer.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] col_next, row_next;
	logic             col_last, row_last;
	pos_tag_t         tag_in;

	assign col_next    = DIM_W'(col_q) + DIM_W'(1);
	assign row_next    = DIM_W'(row_q) + DIM_W'(1);
	assign col_last    = col_next >= w_eff;
	assign row_last    = row_next >= h_eff;
	assign tag_in.emit = (DIM_W'(col_q) >= DIM_W'(EDGE_MIN)) && (DIM_W'(row_q) >= DIM_W'(EDGE_MIN));
	assign tag_in.last = col_last && row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage one: the line store is read at the pixel's column. The entry is
	// rewritten as the pixel moves on, well before that column comes round
	// again, since a row is at least three pixels long.
	// ------------------------------------------------------------------
	pix_t             px_s1;
	logic [COL_W-1:0] col_s1;
	line_pair_t       rd_pair;
	line_pair_t       wr_pair;
	logic             lines_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free1) begin
			v_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= pixels.pixel;
			col_s1 <= col_q;
			tag_s1 <= tag_in;
		end
	end

	assign lines_we     = v_s1 && free2;
	assign wr_pair.row1 = px_s1;
	assign wr_pair.row2 = rd_pair.row1;

	c3f_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_pair),
		.wr_en   (lines_we),
		.wr_addr (col_s1),
		.wr_data (wr_pair)
	);

	// ------------------------------------------------------------------
	// Stages two and three: the cell row. The new column enters the right
	// cell and every cell passes its column to the left neighbour, so the
	// three cells together are the window; cell 0 is its left column.
	// ------------------------------------------------------------------
	pix_col_t  new_col;
	pix_col_t  cell_in  [3];
	pix_col_t  cell_out [3];
	pix_col_t  cell_coef [3];
	colsum_t   cell_sum [3];
	cell_ctl_t cell_ctl;

	assign new_col[0]      = rd_pair.row2;
	assign new_col[1]      = rd_pair.row1;
	assign new_col[2]      = px_s1;
	assign cell_ctl.shift  = v_s1 && free2;
	assign cell_ctl.sum_en = v_s2 && free3;

	for (genvar k = 0; k < 3; k++) begin : g_cell
		if (k == 2) begin : g_right
			assign cell_in[k] = new_col;
		end else begin : g_inner
			assign cell_in[k] = cell_out[k+1];
		end

		for (genvar r = 0; r < 3; r++) begin : g_coef
			assign cell_coef[k][r] = krow_q[r][COEF_W*k +: COEF_W];
		end

		c3f_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.col_in  (cell_in[k]),
			.coef    (cell_coef[k]),
			.col_out (cell_out[k]),
			.colsum  (cell_sum[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (free2) begin
				v_s2 <= v_s1;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cell_ctl.shift) begin
			tag_s2 <= tag_s1;
		end
		if (cell_ctl.sum_en) begin
			tag_s3 <= tag_s2;
		end
	end

	// ------------------------------------------------------------------
	// Output register: the three column sums are added as an interior
	// result is taken in. It is loaded whenever it is empty or its result
	// is being transferred, so the stream keeps flowing behind it.
	// ------------------------------------------------------------------
	sum_t filtered_q;
	logic last_q;
	logic out_load;

	assign out_load = v_s3 && tag_s3.emit && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= v_s3 && tag_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= sum_t'(cell_sum[0]) + sum_t'(cell_sum[1]) + sum_t'(cell_sum[2]);
			last_q     <= tag_s3.last;
		end
	end

	assign results.valid     = out_v_q;
	assign results.filtered  = filtered_q;
	assign results.frame_end = last_q;

	// ------------------------------------------------------------------
	// Checks on the core's own control.
	// ------------------------------------------------------------------
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && col_last |=> col_q == '0)
		else $error("column counter did not wrap at the end of a row");

	a_line_rw: assert property (@(posedge clk) disable iff (!arst_n)
		lines_we && accept |-> col_s1 != col_q)
		else $error("line store written and read at the same column");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !free2 |=> v_s1 && $stable(col_s1) && $stable(px_s1))
		else $error("stage one lost its pixel while stalled");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s3 && tag_s3.emit))
		else $error("result offered without an interior pixel behind it");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for conv3x3_image_filter_core: streams images through the
// pixel channel, predicts every 3x3 window sum and checks the result channel against it.
// Depends on c3f_pkg, c3f_pixel_if, c3f_result_if and the core itself.
`timescale 1ns / 1ps

module tb;
	import c3f_pkg::*;

	// One expected result of the core, in the order the core must deliver them.
	typedef struct packed {
		sum_t filtered;
		logic frame_end;
	} conv_result_t;

	// Scoreboard that keeps its own copy of the kernel, the frame size, the line stores,
	// the window and the position counters. Every accepted pixel is fed in; each pixel
	// that closes an interior window leaves one expected sum in the queue.
	class window_sum_board;
		logic [KROW_W-1:0]   kernel [3];
		logic [DIMCFG_W-1:0] width_reg;
		logic [DIMCFG_W-1:0] height_reg;
		pix_t                row_above [MAX_WIDTH_DEF];
		pix_t                row_above2 [MAX_WIDTH_DEF];
		pix_t                win [3][3];
		int unsigned         col_pos;
		int unsigned         row_pos;
		conv_result_t        pending_sums [$];
		int unsigned         errors;

		function void restart();
			foreach (kernel[i])
				kernel[i] = KROW_RESET;
			width_reg  = DIM_RESET;
			height_reg = DIM_RESET;
			foreach (row_above[i]) begin
				row_above[i]  = '0;
				row_above2[i] = '0;
			end
			foreach (win[i, k])
				win[i][k] = '0;
			col_pos = 0;
			row_pos = 0;
			pending_sums.delete();
			errors = 0;
		endfunction

		static function int unsigned clamp_dim(logic [DIMCFG_W-1:0] value, int unsigned hi);
			if (value < DIM_MIN)
				return DIM_MIN;
			if (value > hi)
				return hi;
			return 32'(value);
		endfunction

		function void apply_setting(cfg_index_t idx, logic [KROW_W-1:0] data);
			case (idx)
				REG_KROW_TOP: kernel[0] = data;
				REG_KROW_MID: kernel[1] = data;
				REG_KROW_BOT: kernel[2] = data;
				REG_WIDTH:    width_reg = data[DIMCFG_W-1:0];
				REG_HEIGHT:   height_reg = data[DIMCFG_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_pixel(pix_t value);
			int unsigned  w;
			int unsigned  h;
			int unsigned  c;
			int unsigned  r;
			int unsigned  slot;
			pix_t         upper;
			pix_t         middle;
			longint       acc;
			conv_result_t res;

			w    = clamp_dim(width_reg, MAX_WIDTH_DEF);
			h    = clamp_dim(height_reg, MAX_HEIGHT_DEF);
			c    = col_pos;
			r    = row_pos;
			slot = c % MAX_WIDTH_DEF;

			upper  = row_above2[slot];
			middle = row_above[slot];
			row_above2[slot] = middle;
			row_above[slot]  = value;

			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = upper;
			win[1][2] = middle;
			win[2][2] = value;

			if (r >= EDGE_MIN && c >= EDGE_MIN) begin
				acc = 0;
				for (int i = 0; i < 3; i++)
					for (int k = 0; k < 3; k++)
						acc += longint'(win[i][k]) *
							longint'(pix_t'(kernel[i][COEF_W*k +: COEF_W]));
				res.filtered  = sum_t'(acc);
				res.frame_end = (r + 1 >= h) && (c + 1 >= w);
				pending_sums.push_back(res);
			end

			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 100)
				$display("%0t: %s", $time, what);
		endtask

		task check_sum(sum_t got, logic got_end);
			conv_result_t want;

			if (pending_sums.size() == 0) begin
				report($sformatf("result %0d arrived with no sum outstanding", got));
				return;
			end
			want = pending_sums.pop_front();
			if (got !== want.filtered)
				report($sformatf("filtered is %0d, should be %0d", got, want.filtered));
			if (got_end !== want.frame_end)
				report($sformatf("frame_end is %b, should be %b", got_end, want.frame_end));
		endtask
	endclass

	// Random pixels after the line stores have been filled.
	localparam int RANDOM_ITEMS = 1500;
	// Columns of the line stores filled before the random phases. Later widths stay
	// within them, so every interior window reads entries that have been written.
	localparam int FILL_WIDTH = 80;
	// Percentage of cycles in which either side holds back.
	localparam int IDLE_PCT = 8;
	// Cycles allowed after the last sum for a pixel that closes no window to leave the
	// pipeline.
	localparam int SETTLE_CYCLES = 8;

	localparam pix_t PIX_MIN = 16'sh8000;
	localparam pix_t PIX_MAX = 16'sh7FFF;

	logic                clk;
	logic                arst_n;
	logic                cfg_write;
	cfg_index_t          cfg_index;
	logic [KROW_W-1:0]   cfg_data;
	bit                  gaps_on = 1'b1;
	window_sum_board     board;

	c3f_pixel_if  pix_ch ();
	c3f_result_if res_ch ();

	conv3x3_image_filter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_ch),
		.results   (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Coefficients and pixels lean towards the extremes now and then, so that the
	// largest products and sign changes turn up often.
	function automatic logic [COEF_W-1:0] rand_coef();
		logic [COEF_W-1:0] bits;

		bits = COEF_W'($urandom);
		case ($urandom_range(0, 11))
			0: bits = PIX_MIN;
			1: bits = PIX_MAX;
			2: bits = '0;
			3: bits = '1;
			default: ;
		endcase
		return bits;
	endfunction

	function automatic pix_t rand_pixel();
		return pix_t'(rand_coef());
	endfunction

	function automatic logic [KROW_W-1:0] rand_krow();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	// A frame dimension: mostly small, sometimes below the legal range and, for the
	// height, sometimes above it (both saturate), sometimes with junk in the unused
	// upper bits of the word. Widths stay within the filled columns of the line stores.
	function automatic logic [KROW_W-1:0] dim_value(bit above_ok);
		logic [KROW_W-1:0] word;

		word = {16'($urandom), 32'($urandom)};
		case ($urandom_range(0, 9))
			0: word[DIMCFG_W-1:0] = DIMCFG_W'($urandom_range(0, DIM_MIN - 1));
			1: begin
				if (above_ok)
					word[DIMCFG_W-1:0] =
						DIMCFG_W'($urandom_range(MAX_HEIGHT_DEF, (1 << DIMCFG_W) - 1));
				else
					word[DIMCFG_W-1:0] = DIMCFG_W'($urandom_range(13, FILL_WIDTH));
			end
			2: word[DIMCFG_W-1:0] = DIMCFG_W'($urandom_range(13, FILL_WIDTH));
			default: word[DIMCFG_W-1:0] = DIMCFG_W'($urandom_range(DIM_MIN, 12));
		endcase
		if ($urandom_range(0, 1))
			word[KROW_W-1:DIMCFG_W] = '0;
		return word;
	endfunction

	// Offer one pixel, possibly after a few idle cycles, and hold it until the core
	// takes it. The scoreboard sees the pixel at the edge of the transfer.
	task automatic send_pixel(pix_t value);
		while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= value;
		@(posedge clk);
		while (pix_ch.ready !== 1'b1)
			@(posedge clk);
		board.take_pixel(value);
	endtask

	// Stop sending and wait until every predicted sum has been delivered, then give any
	// pixel still in the pipeline time to leave it. The core is idle afterwards.
	task automatic wait_results_out();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write, followed by a quiet cycle so that back-to-back writes never
	// lower and raise the enable in the same time step.
	task automatic write_setting(cfg_index_t idx, logic [KROW_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.apply_setting(idx, data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: check every transfer and choose the ready for the next cycle.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				board.check_sum(res_ch.filtered, res_ch.frame_end);
			res_ch.ready <= !gaps_on || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	// Main sequence.
	initial begin
		pix_t        mixed [9];
		int unsigned n;
		int unsigned random_sent;
		int unsigned phase;

		board = new;
		board.restart();
		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= REG_KROW_TOP;
		cfg_data     <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The smallest frame, 3x3, closes exactly one window, which is also
		// the last of the frame. With every coefficient and pixel at the negative extreme
		// the sum reaches its largest positive value; with the pixels at the positive
		// extreme it reaches the most negative one. The two frames run back to back.
		write_setting(REG_KROW_TOP, {3{PIX_MIN}});
		write_setting(REG_KROW_MID, {3{PIX_MIN}});
		write_setting(REG_KROW_BOT, {3{PIX_MIN}});
		write_setting(REG_WIDTH, KROW_W'(DIM_MIN));
		write_setting(REG_HEIGHT, KROW_W'(DIM_MIN));
		repeat (9) send_pixel(PIX_MIN);
		repeat (9) send_pixel(PIX_MAX);
		wait_results_out();

		// Mixed-sign kernel, a width of two with junk in the upper bits and a height of
		// zero (both must saturate to three), and writes to the indexes beyond the
		// register list, which the core must ignore.
		write_setting(REG_KROW_TOP, {PIX_MAX, PIX_MIN, 16'h0001});
		write_setting(REG_KROW_MID, {16'hFFFF, 16'h0000, PIX_MAX});
		write_setting(REG_KROW_BOT, {PIX_MIN, PIX_MAX, 16'hFFFF});
		write_setting(REG_WIDTH, 48'hFFFF_FFFF_F802);
		write_setting(REG_HEIGHT, '0);
		for (int k = 1; k <= 3; k++)
			write_setting(cfg_index_t'(REG_HEIGHT + k), {16'($urandom), 32'($urandom)});
		mixed = '{PIX_MIN, PIX_MAX, 16'sh0000, -16'sh0001, 16'sh0001,
			PIX_MAX, PIX_MIN, 16'sh5555, -16'sh5556};
		foreach (mixed[i])
			send_pixel(mixed[i]);
		wait_results_out();

		// Fill both line stores over the first FILL_WIDTH columns. From here on every
		// entry that a later width can reach has been written, so later phases may
		// change the width in the middle of a frame.
		write_setting(REG_WIDTH, KROW_W'(FILL_WIDTH));
		write_setting(REG_HEIGHT, KROW_W'(DIM_MIN));
		write_setting(REG_KROW_TOP, rand_krow());
		write_setting(REG_KROW_MID, rand_krow());
		write_setting(REG_KROW_BOT, rand_krow());
		repeat (2 * FILL_WIDTH + $urandom_range(40, 100)) send_pixel(rand_pixel());

		// Random phases. Each one drains the core, rewrites a random choice of registers
		// and streams a burst of pixels. Bursts end anywhere in a frame, so new sizes
		// often take effect with the counters already past the new bounds. One phase
		// runs without idling on either side.
		random_sent = 0;
		phase       = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wait_results_out();
			for (int i = 0; i < 3; i++)
				if ($urandom_range(0, 1))
					write_setting(cfg_index_t'(REG_KROW_TOP + i), rand_krow());
			if ($urandom_range(0, 1))
				write_setting(REG_WIDTH, dim_value(1'b0));
			if ($urandom_range(0, 1))
				write_setting(REG_HEIGHT, dim_value(1'b1));
			if ($urandom_range(0, 7) == 0)
				write_setting(cfg_index_t'(REG_HEIGHT + 1 + $urandom_range(0, 2)),
					{16'($urandom), 32'($urandom)});
			gaps_on = (phase != 3);
			n = gaps_on ? $urandom_range(20, 160) : 400;
			repeat (n) send_pixel(rand_pixel());
			random_sent += n;
			phase++;
		end
		gaps_on = 1'b1;

		// Let the last sums out and leave room for any stray transfer to show up.
		wait_results_out();
		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
